[rtl/modular_exponentiation_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the modular exponentiation block
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication
`define MEXP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define MEXP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mexp_pkg.sv]
// ---------------------------------------------------------------------------
// mexp_pkg
// Sequencer states and action codes for the modular exponentiation block.
// ---------------------------------------------------------------------------
package mexp_pkg;

	// Action codes carried on the input transfer
	localparam logic ACT_POWER   = 1'b0;
	localparam logic ACT_INVERSE = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_MUL_ACC,
		ST_MUL_SQ,
		ST_FINISH
	} mexp_state_t;

endpackage

[rtl/modular_exponentiation.sv]
// ---------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus (base^(modulus-2) for the inverse action) by
// right-to-left square-and-multiply, every modular product formed on one
// shared shift-add reducing unit, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | action, base, exponent, modulus
//  out     | out_valid / out_ready| residue, modulus_error
//
//  Per item: the base is first reduced mod the modulus, then each exponent
//  bit takes a check and up to two modular products (accumulate, square),
//  and the finish state loads the output register.
//  A zero modulus goes straight to the finish state.
//  in_ready is high only when the sequencer is idle; a finished result
//  waits in the output register without holding off the next transfer.
//  arst_n clears the sequencer and the output valid flag.
//
module modular_exponentiation #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [DATA_WIDTH-1:0] base,
	input  logic [DATA_WIDTH-1:0] exponent,
	input  logic [DATA_WIDTH-1:0] modulus,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] residue,
	output logic                  modulus_error
);
	import mexp_pkg::*;

	`include "modular_exponentiation_defines.svh"

	localparam int CntW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
	localparam int SumW = DATA_WIDTH + 2;
	localparam logic [DATA_WIDTH-1:0] One = DATA_WIDTH'(1);
	localparam logic [DATA_WIDTH-1:0] Two = DATA_WIDTH'(2);
	localparam logic [CntW-1:0] LastCnt = CntW'(DATA_WIDTH - 1);

	mexp_state_t state_q, state_d;

	logic [DATA_WIDTH-1:0] m_q;     // modulus
	logic [DATA_WIDTH-1:0] e_q;     // remaining exponent
	logic [DATA_WIDTH-1:0] acc_q;   // running power
	logic [DATA_WIDTH-1:0] sq_q;    // running square
	logic [DATA_WIDTH-1:0] prod_q;  // product being built
	logic [DATA_WIDTH-1:0] mplr_q;  // multiplier, scanned from the top
	logic                  err_q;
	logic [CntW-1:0]       cnt_q;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] residue_q;
	logic                  mod_err_q;

	logic                  accept;
	logic                  last_bit;
	logic                  load_out;
	logic [DATA_WIDTH-1:0] addend;
	logic [SumW-1:0]       sum;
	logic [SumW-1:0]       m1_ext;
	logic [SumW-1:0]       m2_ext;
	logic [SumW-1:0]       red_ext;
	logic [DATA_WIDTH-1:0] red;

	assign accept   = in_valid && in_ready;
	assign last_bit = (cnt_q == LastCnt);

	// Shared unit: (2*prod + addend) mod m, the sum always below 3m
	always_comb begin
		if (state_q == ST_REDUCE) begin
			addend = {{(DATA_WIDTH-1){1'b0}}, mplr_q[DATA_WIDTH-1]};
		end else begin
			addend = mplr_q[DATA_WIDTH-1] ? sq_q : '0;
		end
		sum    = {1'b0, prod_q, 1'b0} + {2'b00, addend};
		m1_ext = {2'b00, m_q};
		m2_ext = {1'b0, m_q, 1'b0};
		priority if (sum >= m2_ext) begin
			red_ext = sum - m2_ext;
		end else if (sum >= m1_ext) begin
			red_ext = sum - m1_ext;
		end else begin
			red_ext = sum;
		end
		red = red_ext[DATA_WIDTH-1:0];
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (modulus == '0) ? ST_FINISH : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (last_bit) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (e_q == '0) begin
					state_d = ST_FINISH;
				end else if (e_q[0]) begin
					state_d = ST_MUL_ACC;
				end else begin
					state_d = ST_MUL_SQ;
				end
			end
			ST_MUL_ACC: begin
				if (last_bit) begin
					state_d = (e_q[DATA_WIDTH-1:1] == '0) ? ST_FINISH : ST_MUL_SQ;
				end
			end
			ST_MUL_SQ: begin
				if (last_bit) begin
					state_d = ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Bit counter for the shared unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_REDUCE || state_q == ST_MUL_ACC ||
				state_q == ST_MUL_SQ) begin
			cnt_q <= last_bit ? '0 : cnt_q + CntW'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// Operand and product registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					m_q    <= modulus;
					e_q    <= (action == ACT_INVERSE) ? modulus - Two : exponent;
					acc_q  <= (modulus == One || modulus == '0) ? '0 : One;
					err_q  <= (modulus == '0);
					mplr_q <= base;
					prod_q <= '0;
				end
			end
			ST_REDUCE: begin
				prod_q <= red;
				mplr_q <= {mplr_q[DATA_WIDTH-2:0], 1'b0};
				if (last_bit) begin
					sq_q <= red;
				end
			end
			ST_CHECK: begin
				mplr_q <= e_q[0] ? acc_q : sq_q;
				prod_q <= '0;
			end
			ST_MUL_ACC: begin
				prod_q <= red;
				mplr_q <= {mplr_q[DATA_WIDTH-2:0], 1'b0};
				if (last_bit) begin
					acc_q  <= red;
					mplr_q <= sq_q;
					prod_q <= '0;
				end
			end
			ST_MUL_SQ: begin
				prod_q <= red;
				mplr_q <= {mplr_q[DATA_WIDTH-2:0], 1'b0};
				if (last_bit) begin
					sq_q <= red;
					e_q  <= {1'b0, e_q[DATA_WIDTH-1:1]};
				end
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			residue_q <= acc_q;
			mod_err_q <= err_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign residue       = residue_q;
	assign modulus_error = mod_err_q;

	// Checks
	`MEXP_ASSERT_IMP(a_err_gives_zero, out_valid && modulus_error, residue == '0, "error result not zero")
	`MEXP_ASSERT_NXT(a_zero_mod_finish, accept && modulus == '0, state_q == ST_FINISH, "zero modulus not short-cut")
	`MEXP_ASSERT_IMP(a_prod_reduced, state_q == ST_MUL_ACC || state_q == ST_MUL_SQ || state_q == ST_REDUCE, prod_q < m_q, "partial product not reduced")
	`MEXP_ASSERT_IMP(a_ops_reduced, state_q == ST_CHECK || state_q == ST_MUL_ACC || state_q == ST_MUL_SQ, acc_q < m_q && sq_q < m_q, "operand not reduced")

endmodule
